>>> hdl/b64d_pkg.sv
package b64d_pkg;

  localparam logic [1:0] CFG_CHAR_SIXTY_TWO   = 2'd0;
  localparam logic [1:0] CFG_CHAR_SIXTY_THREE = 2'd1;
  localparam logic [1:0] CFG_PAD_CHAR         = 2'd2;
  localparam logic [1:0] CFG_PAD_SHORT_TAIL   = 2'd3;

  localparam logic [7:0] RST_CHAR_SIXTY_TWO   = 8'd43;
  localparam logic [7:0] RST_CHAR_SIXTY_THREE = 8'd47;
  localparam logic [7:0] RST_PAD_CHAR         = 8'd61;
  localparam logic       RST_PAD_SHORT_TAIL   = 1'b1;

  // bit 6 marks a pad, bits 5:0 carry the sextet
  localparam logic [6:0] PAD_SEXTET = 7'h40;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       message_end;
    logic       error;
  } out_item_t;

  // one decoded event, expands to nres results in the back end
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nres;
    logic            valid;
    logic            last_end;
    logic            err;
  } rec_t;

endpackage

>>> hdl/b64d_front.sv
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       acc,
  input  in_item_t   item,
  output logic       push,
  output rec_t       rec
);

  logic [7:0] c62_r, c63_r, pad_r;
  logic       short_r;
  logic [6:0] held_r [3];
  logic [1:0] pos_r, pos_nxt;
  logic       skip_r, skip_nxt;

  logic [7:0] c;
  logic       eom;
  logic       bad;
  logic [6:0] mv;
  logic [6:0] sx [4];
  logic [3:0] pads;
  logic       store;

  assign c   = item.char_code;
  assign eom = item.end_of_message;

  always_comb begin
    bad = 1'b0;
    mv  = 7'd0;
    if (c == pad_r) begin
      mv = PAD_SEXTET;
    end else if (c == c62_r) begin
      mv = 7'd62;
    end else if (c == c63_r) begin
      mv = 7'd63;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      mv = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      mv = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      mv = 7'(c - 8'h30 + 8'd52);
    end else begin
      bad = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < pos_r && i < 3) begin
        sx[i] = held_r[i];
      end else if (2'(i) == pos_r) begin
        sx[i] = mv;
      end else begin
        sx[i] = PAD_SEXTET;
      end
      pads[i] = sx[i][6];
    end
  end

  always_comb begin
    push     = 1'b0;
    store    = 1'b0;
    pos_nxt  = pos_r;
    skip_nxt = skip_r;
    rec      = '0;
    rec.nres = 2'd1;
    if (acc) begin
      if (skip_r) begin
        if (eom) begin
          push         = 1'b1;
          rec.last_end = 1'b1;
          skip_nxt     = 1'b0;
          pos_nxt      = 2'd0;
        end
      end else if (bad) begin
        push         = 1'b1;
        rec.err      = 1'b1;
        rec.last_end = eom;
        skip_nxt     = !eom;
        pos_nxt      = 2'd0;
      end else if (pos_r < 2'd3 && !eom) begin
        store   = 1'b1;
        pos_nxt = pos_r + 2'd1;
      end else begin
        push    = 1'b1;
        pos_nxt = 2'd0;
        rec.bytes[0] = {sx[0][5:0], sx[1][5:4]};
        rec.bytes[1] = {sx[1][3:0], sx[2][5:2]};
        rec.bytes[2] = {sx[2][1:0], sx[3][5:0]};
        if (!eom) begin
          if (pads != 4'h0) begin
            rec.bytes = '0;
            rec.err   = 1'b1;
            skip_nxt  = 1'b1;
          end else begin
            rec.nres  = 2'd3;
            rec.valid = 1'b1;
          end
        end else begin
          rec.last_end = 1'b1;
          if (pos_r < 2'd3 && !short_r) begin
            rec.bytes = '0;
          end else begin
            case (pads)
              4'h0: begin
                rec.nres  = 2'd3;
                rec.valid = 1'b1;
              end
              4'he: begin
                rec.bytes    = '0;
                rec.bytes[0] = {sx[0][5:0], 2'b00};
                rec.valid    = 1'b1;
              end
              4'hc: begin
                rec.bytes[1] = 8'd0;
                rec.bytes[2] = 8'd0;
                rec.valid    = 1'b1;
              end
              4'h8: begin
                rec.bytes[2] = 8'd0;
                rec.nres     = 2'd2;
                rec.valid    = 1'b1;
              end
              default: begin
                rec.bytes = '0;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c62_r   <= RST_CHAR_SIXTY_TWO;
      c63_r   <= RST_CHAR_SIXTY_THREE;
      pad_r   <= RST_PAD_CHAR;
      short_r <= RST_PAD_SHORT_TAIL;
      pos_r   <= 2'd0;
      skip_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      skip_r <= skip_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAR_SIXTY_TWO:   c62_r   <= cfg_wdata;
          CFG_CHAR_SIXTY_THREE: c63_r   <= cfg_wdata;
          CFG_PAD_CHAR:         pad_r   <= cfg_wdata;
          CFG_PAD_SHORT_TAIL:   short_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      held_r[pos_r] <= mv;
    end
  end

  a_err_starts_skip: assert property (@(posedge clk) disable iff (!rst_n)
    push && rec.err && !rec.last_end |=> skip_r)
    else $error("error inside a message did not start skipping");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r && acc && !eom |-> !push)
    else $error("result produced while skipping");

  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && eom |=> pos_r == 2'd0 && !skip_r)
    else $error("state not cleared at end of message");

endmodule

>>> hdl/b64d_queue.sv
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  rec_t wr_data,
  input  logic rd_en,
  output rec_t head,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rp_r];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wrap_inc(wp_r);
      end
      if (rd_en) begin
        rp_r <= wrap_inc(rp_r);
      end
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> hdl/b64d_back.sv
module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rec_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_r;
  logic       load;
  logic       last;

  assign load      = !empty && (!out_valid_r || out_ready);
  assign last      = idx_r == head.nres - 2'd1;
  assign pop       = load && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.data        <= head.bytes[idx_r];
      out_r.data_valid  <= head.valid;
      out_r.message_end <= last && head.last_end;
      out_r.error       <= head.err;
    end
  end

endmodule

>>> hdl/base64_quad_decoder.sv
// channel  direction  handshake                 payload
// in       input      in_valid / in_ready       in_data (char_code, end_of_message)
// out      output     out_valid / out_ready     out_data (data, data_valid, message_end, error)
// cfg      input      cfg_we                    cfg_index, cfg_wdata
//
// one character per cycle while in_ready is high; a full group yields three results,
// one per cycle while out_ready is high, set by the single output register of the back end
// the record queue between front and back absorbs result bursts
// in_ready drops only while the record queue is full
// synchronous active-low reset clears group position, skip flag, queue and output
module base64_quad_decoder
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic acc, push, pop, full, empty;
  rec_t rec, head;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (in_data),
    .push      (push),
    .rec       (rec)
  );

  b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (rec),
    .rd_en   (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/b64d_result_checker.sv
`timescale 1ns / 1ps

module b64d_result_checker
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         failures,
  output int         awaiting
);

  localparam logic [7:0] BAD_SEXTET = 8'h80;
  localparam logic [7:0] PAD_CODE   = {1'b0, PAD_SEXTET};

  logic [7:0] sym_62;
  logic [7:0] sym_63;
  logic [7:0] sym_pad;
  logic       fill_tail;

  logic [7:0] group_sextets [3];
  int         group_fill;
  logic       discarding;

  out_item_t  owed_results [$];
  int         mismatch_count = 0;

  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    if (c == sym_pad) return PAD_CODE;
    if (c == sym_62) return 8'd62;
    if (c == sym_63) return 8'd63;
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    return BAD_SEXTET;
  endfunction

  task automatic owe(input logic [7:0] data, input logic valid, input logic last,
                     input logic err);
    out_item_t r;
    r.data = data;
    r.data_valid = valid;
    r.message_end = last;
    r.error = err;
    owed_results.push_back(r);
  endtask

  task automatic clear_group();
    foreach (group_sextets[i]) group_sextets[i] = '0;
    group_fill = 0;
  endtask

  task automatic decode_char_transfer(input in_item_t t);
    logic [7:0]  v;
    logic [7:0]  s [4];
    logic [3:0]  pads;
    logic [23:0] word;
    int          n;
    int          nbytes;
    if (discarding) begin
      if (t.end_of_message) begin
        discarding = 1'b0;
        clear_group();
        owe(8'h00, 1'b0, 1'b1, 1'b0);
      end
      return;
    end
    v = sextet_of(t.char_code);
    if (v == BAD_SEXTET) begin
      clear_group();
      discarding = !t.end_of_message;
      owe(8'h00, 1'b0, t.end_of_message, 1'b1);
      return;
    end
    if (group_fill < 3 && !t.end_of_message) begin
      group_sextets[group_fill] = v;
      group_fill++;
      return;
    end
    n = group_fill + 1;
    for (int i = 0; i < 4; i++) begin
      if (i < n - 1) s[i] = group_sextets[i];
      else if (i == n - 1) s[i] = v;
      else s[i] = PAD_CODE;
      pads[i] = s[i][6];
    end
    clear_group();
    word = {s[0][5:0], s[1][5:0], s[2][5:0], s[3][5:0]};
    if (!t.end_of_message) begin
      if (pads != 4'b0000) begin
        discarding = 1'b1;
        owe(8'h00, 1'b0, 1'b0, 1'b1);
      end else begin
        owe(word[23:16], 1'b1, 1'b0, 1'b0);
        owe(word[15:8], 1'b1, 1'b0, 1'b0);
        owe(word[7:0], 1'b1, 1'b0, 1'b0);
      end
      return;
    end
    if (n < 4 && !fill_tail) begin
      owe(8'h00, 1'b0, 1'b1, 1'b0);
      return;
    end
    case (pads) inside
      4'b0000: nbytes = 3;
      4'b1000: nbytes = 2;
      4'b1100, 4'b1110: nbytes = 1;
      default: nbytes = 0;
    endcase
    if (nbytes == 0) begin
      owe(8'h00, 1'b0, 1'b1, 1'b0);
      return;
    end
    for (int i = 0; i < nbytes; i++) begin
      owe(word[23 - 8 * i -: 8], 1'b1, i == nbytes - 1, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sym_62 = RST_CHAR_SIXTY_TWO;
      sym_63 = RST_CHAR_SIXTY_THREE;
      sym_pad = RST_PAD_CHAR;
      fill_tail = RST_PAD_SHORT_TAIL;
      clear_group();
      discarding = 1'b0;
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected transfer, actual data %02h valid %b end %b error %b",
                   $time, out_data.data, out_data.data_valid, out_data.message_end,
                   out_data.error);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (want !== out_data) begin
            $display("%0t: expected data %02h valid %b end %b error %b, actual data %02h valid %b end %b error %b",
                     $time, want.data, want.data_valid, want.message_end, want.error,
                     out_data.data, out_data.data_valid, out_data.message_end,
                     out_data.error);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) decode_char_transfer(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAR_SIXTY_TWO:   sym_62 = cfg_wdata;
          CFG_CHAR_SIXTY_THREE: sym_63 = cfg_wdata;
          CFG_PAD_CHAR:         sym_pad = cfg_wdata;
          CFG_PAD_SHORT_TAIL:   fill_tail = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    failures <= mismatch_count;
    awaiting <= owed_results.size();
  end

endmodule

>>> tb/base64_quad_decoder_test.sv
`timescale 1ns / 1ps

module base64_quad_decoder_test
  import b64d_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 18;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CHAR_SIXTY_TWO;
  logic [7:0] cfg_wdata = 8'h00;

  int failures;
  int awaiting;
  int idle_cycles = 0;
  int phase_items;

  logic [7:0] cur_62 = RST_CHAR_SIXTY_TWO;
  logic [7:0] cur_63 = RST_CHAR_SIXTY_THREE;
  logic [7:0] cur_pad = RST_PAD_CHAR;
  bit         no_gaps = 1'b0;

  base64_quad_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  b64d_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .awaiting  (awaiting)
  );

  always #1 clk = ~clk;

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] alpha_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? cur_62 : cur_63;
  endfunction

  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return "*";
      3: return " ";
      default: return 8'(8'h80 + $urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eom);
    int gap;
    gap = no_gaps ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, end_of_message: eom};
    do @(posedge clk); while (!in_ready);
    phase_items++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] s62, input logic [7:0] s63,
                               input logic [7:0] spad, input logic tail);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHAR_SIXTY_TWO;
    cfg_wdata <= s62;
    @(posedge clk);
    cfg_index <= CFG_CHAR_SIXTY_THREE;
    cfg_wdata <= s63;
    @(posedge clk);
    cfg_index <= CFG_PAD_CHAR;
    cfg_wdata <= spad;
    @(posedge clk);
    cfg_index <= CFG_PAD_SHORT_TAIL;
    cfg_wdata <= {7'd0, tail};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_62 = s62;
    cur_63 = s63;
    cur_pad = spad;
  endtask

  task automatic send_message();
    logic [7:0] text [$];
    int groups;
    no_gaps = ($urandom_range(0, 3) == 0);
    groups = $urandom_range(0, 2);
    repeat (4 * groups) text.push_back(alpha_char());
    case ($urandom_range(0, 11))
      0, 1, 2: repeat (4) text.push_back(alpha_char());
      3: begin
        repeat (3) text.push_back(alpha_char());
        text.push_back(cur_pad);
      end
      4: begin
        repeat (2) text.push_back(alpha_char());
        repeat (2) text.push_back(cur_pad);
      end
      5: begin
        text.push_back(alpha_char());
        repeat (3) text.push_back(cur_pad);
      end
      6: repeat ($urandom_range(1, 3)) text.push_back(alpha_char());
      7: repeat ($urandom_range(1, 4))
        text.push_back($urandom_range(0, 1) ? alpha_char() : cur_pad);
      8: repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      9: begin
        repeat (4) text.push_back(alpha_char());
        text[$urandom_range(0, text.size() - 1)] = junk_char();
      end
      default: begin
        repeat (4) text.push_back(alpha_char());
        text[$urandom_range(0, text.size() - 1)] = cur_pad;
      end
    endcase
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    int hold;
    forever begin
      hold = pause_len();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("base64_quad_decoder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_settings(RST_CHAR_SIXTY_TWO, RST_CHAR_SIXTY_THREE, RST_PAD_CHAR,
                  RST_PAD_SHORT_TAIL);

    // directed: c62/c63 and three-byte group, then the tail patterns and bad characters
    send_text("/+9zQUI=");
    send_text("Q===");
    send_text("AA");
    send_text("=");
    send_char("Q", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("x", 1'b1);
    send_text("A=A=B");
    send_char("z", 1'b0);
    send_char(8'h00, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: load_settings(RST_CHAR_SIXTY_TWO, RST_CHAR_SIXTY_THREE, RST_PAD_CHAR, 1'b0);
        1: load_settings(8'h00, 8'hFF, 8'h80, 1'b0);
        2: load_settings(8'hFF, 8'h00, "A", 1'b1);
        3: load_settings("-", "_", ".", 1'b1);
        4: load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: load_settings(RST_CHAR_SIXTY_TWO, RST_CHAR_SIXTY_THREE, RST_PAD_CHAR,
                               RST_PAD_SHORT_TAIL);
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_message();
    end

    settle();
    if (failures == 0) begin
      $display("base64_quad_decoder: match");
    end else begin
      $display("base64_quad_decoder: mismatch");
    end
    $finish;
  end

endmodule
